/* sv/kcme_pkg.sv */
// Shared constants and types for the key change MIDI note event block.
package kcme_pkg;

  localparam int KEY_W       = 24;
  localparam int KEY_IDX_W   = $clog2(KEY_W);
  localparam int RANGE_W     = 3;
  localparam int MAX_RANGE   = 7;
  localparam int NOTE_BITS   = 7;
  localparam int VEL_W       = 7;
  localparam int STATUS_W    = 8;
  localparam int MAX_NOTE    = 127;

  localparam logic [STATUS_W-1:0] NOTE_ON_STATUS  = 8'h90;
  localparam logic [STATUS_W-1:0] NOTE_OFF_STATUS = 8'h80;

  localparam int DEF_NUM_KEYS    = 24;
  localparam int DEF_RANGE_STEP  = 24;
  localparam int DEF_QUEUE_DEPTH = 2;

  // One classified scan: keys that will send a message, new key levels, note base.
  typedef struct packed {
    logic [KEY_W-1:0]     events;
    logic [KEY_W-1:0]     keys;
    logic [NOTE_BITS-1:0] base;
  } kcme_entry_t;

endpackage

/* sv/key_change_midi_note_events_core.sv */
// Top level of the key change MIDI note event block.
//
// Each accepted scan of key_bits is compared with the previous scan; every changed
// key whose note (key index plus RANGE_STEP times octave_range) is at most 127 gives
// one MIDI message, note-on 0x90 for a press and note-off 0x80 for a release, in
// ascending key order, with last set on the scan's final message. Scans that change
// nothing in range give no message but still update the stored scan, which reset
// clears. The front end takes a scan and hands it to a queue of QUEUE_DEPTH scans;
// the back end loads a scan from the queue when it is idle and then sends one
// message per cycle while out_ready is high, taking the next scan only once the
// last message of the current one has been issued. A scan is accepted
// whenever the queue has room, so the front keeps taking scans while messages of
// earlier ones are still waiting. note_velocity is written through the cfg channel
// (cfg_ready is always high) and is copied into every message; write it only while
// no message is pending.
module key_change_midi_note_events_core #(
  parameter int NUM_KEYS    = kcme_pkg::DEF_NUM_KEYS,
  parameter int RANGE_STEP  = kcme_pkg::DEF_RANGE_STEP,
  parameter int QUEUE_DEPTH = kcme_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcme_pkg::VEL_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kcme_pkg::KEY_W-1:0]      key_bits,
  input  logic [kcme_pkg::RANGE_W-1:0]    octave_range,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kcme_pkg::STATUS_W-1:0]   status_byte,
  output logic [kcme_pkg::NOTE_BITS-1:0]  note_number,
  output logic [kcme_pkg::VEL_W-1:0]      velocity,
  output logic                            last
);
  import kcme_pkg::*;

  logic [VEL_W-1:0] note_velocity;
  logic             push_valid;
  logic             push_ready;
  kcme_entry_t      push_entry;
  logic             pop_valid;
  logic             pop_ready;
  kcme_entry_t      pop_entry;

  // Take every configuration transfer at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_velocity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      note_velocity <= cfg_data;
    end
  end

  // Classify scans and advance the stored scan.
  kcme_front #(
    .NUM_KEYS   (NUM_KEYS),
    .RANGE_STEP (RANGE_STEP)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_bits     (key_bits),
    .octave_range (octave_range),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  // Hold classified scans until the back end is free.
  kcme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Send one message per changed key.
  kcme_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .cur_velocity (note_velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status_byte  (status_byte),
    .note_number  (note_number),
    .velocity     (velocity),
    .last         (last)
  );

endmodule

/* sv/kcme_front.sv */
// Front end: accepts scans, finds changed in-range keys, updates the previous scan.
module kcme_front #(
  parameter int NUM_KEYS   = kcme_pkg::DEF_NUM_KEYS,
  parameter int RANGE_STEP = kcme_pkg::DEF_RANGE_STEP
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kcme_pkg::KEY_W-1:0]    key_bits,
  input  logic [kcme_pkg::RANGE_W-1:0]  octave_range,
  output logic                          push_valid,
  input  logic                          push_ready,
  output kcme_pkg::kcme_entry_t         push_entry
);
  import kcme_pkg::*;

  localparam int ACT_KEYS  = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;
  localparam int NOTE_SPAN = RANGE_STEP * MAX_RANGE + KEY_W;
  localparam int NOTE_W    = (NOTE_SPAN > 256) ? $clog2(NOTE_SPAN) : 8;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << ACT_KEYS) - 64'd1);

  logic [KEY_W-1:0]  prev_keys;
  logic [KEY_W-1:0]  keys;
  logic [KEY_W-1:0]  in_range;
  logic [NOTE_W-1:0] base;
  logic              accept;

  assign keys = key_bits & KEY_MASK;
  assign base = NOTE_W'(RANGE_STEP) * NOTE_W'(octave_range);

  // Mark keys whose note stays within the MIDI note range.
  always_comb begin
    for (int k = 0; k < KEY_W; k++) begin
      in_range[k] = (NOTE_W'(k) + base) <= NOTE_W'(MAX_NOTE);
    end
  end

  assign push_entry.events = (keys ^ prev_keys) & in_range;
  assign push_entry.keys   = keys;
  assign push_entry.base   = base[NOTE_BITS-1:0];

  // Scans with no reportable change are dropped after updating the previous scan.
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (push_entry.events != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys <= '0;
    end else if (accept) begin
      prev_keys <= keys;
    end
  end

endmodule

/* sv/kcme_queue.sv */
// Small queue of classified scans between the front and back ends.
module kcme_queue #(
  parameter int DEPTH = kcme_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  kcme_pkg::kcme_entry_t  push_entry,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output kcme_pkg::kcme_entry_t  pop_entry
);
  import kcme_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kcme_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

/* sv/kcme_back.sv */
// Back end: walks one queued scan lowest key first, one message per cycle while out_ready is high.
module kcme_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  kcme_pkg::kcme_entry_t           pop_entry,
  input  logic [kcme_pkg::VEL_W-1:0]      cur_velocity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kcme_pkg::STATUS_W-1:0]   status_byte,
  output logic [kcme_pkg::NOTE_BITS-1:0]  note_number,
  output logic [kcme_pkg::VEL_W-1:0]      velocity,
  output logic                            last
);
  import kcme_pkg::*;

  logic [KEY_W-1:0]     cur_mask;
  logic [KEY_W-1:0]     cur_keys;
  logic [NOTE_BITS-1:0] cur_base;
  logic [KEY_W-1:0]     low_bit;
  logic [KEY_W-1:0]     rest_mask;
  logic [KEY_IDX_W-1:0] low_idx;
  logic                 emit;
  logic                 load;

  assign low_bit   = cur_mask & (~cur_mask + 1'b1);
  assign rest_mask = cur_mask & ~low_bit;

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < KEY_W; k++) begin
      if (low_bit[k]) begin
        low_idx = low_idx | KEY_IDX_W'(k);
      end
    end
  end

  assign pop_ready = (cur_mask == '0);
  assign load      = pop_valid && pop_ready;
  assign emit      = (cur_mask != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_mask <= pop_entry.events;
      end else if (emit) begin
        cur_mask <= rest_mask;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_keys <= pop_entry.keys;
      cur_base <= pop_entry.base;
    end
    if (emit) begin
      status_byte <= ((cur_keys & low_bit) != '0) ? NOTE_ON_STATUS : NOTE_OFF_STATUS;
      note_number <= cur_base + NOTE_BITS'(low_idx);
      velocity    <= cur_velocity;
      last        <= (rest_mask == '0);
    end
  end

`ifndef SYNTH
  a_pop_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    load |-> (cur_mask == '0))
    else $error("queue popped while a scan is still being sent");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && (rest_mask == '0)) |=> (cur_mask == '0 || $past(load)))
    else $error("keys left after the final message of a scan");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_byte == NOTE_ON_STATUS || status_byte == NOTE_OFF_STATUS))
    else $error("message carries an unknown status");

  a_one_bit: assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(low_bit))
    else $error("more than one key selected for one message");
`endif

endmodule
